[sv/quad_motor_mixer_throttle_unit_assert.svh]
// Assertion macros shared by the motor mixer RTL.
// Included by the controller and the datapath; no other dependencies.
`ifndef QUAD_MOTOR_MIXER_THROTTLE_UNIT_ASSERT_SVH
`define QUAD_MOTOR_MIXER_THROTTLE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QMMT_ASSERT_SAME(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QMMT_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/qmmt_pkg.sv]
// Types, constants and small helper functions of the motor mixer.
// Used by qmmt_ctrl, qmmt_datapath and the top level; no dependencies.
package qmmt_pkg;

  localparam int PITCH_W     = 14;
  localparam int ROLL_W      = 14;
  localparam int YAW_W       = 10;
  localparam int LIFT_W      = 17;
  localparam int MODE_W      = 2;
  localparam int ARM_GAIN_W  = 16;
  localparam int YAW_GAIN_W  = 18;
  localparam int QMASS_W     = 14;
  localparam int CMP_W       = 11;
  localparam int CFG_DATA_W  = 18;
  localparam int CFG_INDEX_W = 2;
  localparam int MOTORS      = 4;
  localparam int MOTOR_W     = 2;

  // Throttle curve 2.8189*f^2 + 61.661*f + 320.91, coefficients with 16 fraction bits.
  localparam int CURVE_BITS = 16;
  localparam int CURVE_K2_W = 18;
  localparam int CURVE_K2   = 184739;
  localparam int CURVE_K1   = 4041015;
  localparam int CURVE_K0   = 21031158;

  localparam int THR_MAX  = 850;
  localparam int THR_MIN  = 100;
  localparam int PWM_BASE = 1000;

  // Forces saturate at +/- 2^FORCE_INT_BITS newtons.
  localparam int FORCE_INT_BITS = 6;

  localparam int TERM_CNT_W = 3;
  localparam logic [TERM_CNT_W-1:0] LAST_TERM_INDEX = 3'd4;

  typedef enum logic [MODE_W-1:0] {
    MODE_FOUR_AXIS,
    MODE_PITCH_ONLY,
    MODE_ROLL_ONLY,
    MODE_HOLD
  } mix_mode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MIX_MODE,
    CFG_ARM_GAIN,
    CFG_YAW_GAIN,
    CFG_QUARTER_MASS
  } cfg_reg_t;

  // Operand pairs of the shared multiplier.
  typedef enum logic [2:0] {
    MUL_PITCH,
    MUL_ROLL,
    MUL_YAW,
    MUL_LIFT,
    MUL_HOVER,
    MUL_CURVE_SQ,
    MUL_CURVE_LO,
    MUL_CURVE_HI
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MIX,
    ST_MIX_DRAIN,
    ST_FORCE,
    ST_SQ,
    ST_UWAIT,
    ST_LO,
    ST_HI,
    ST_DRAIN,
    ST_CMP,
    ST_DONE
  } ctl_state_t;

  typedef struct packed {
    logic               load_in;
    logic               mul_en;
    mul_sel_t           mul_sel;
    logic               force_load;
    logic               cmp_write;
    logic [MOTOR_W-1:0] motor;
    logic               out_load;
  } ctl_cmd_t;

  typedef struct packed {
    mix_mode_t mix_mode;
  } dp_status_t;

  function automatic mul_sel_t term_of_index(logic [TERM_CNT_W-1:0] idx);
    mul_sel_t sel;
    case (idx)
      3'd0:    sel = MUL_PITCH;
      3'd1:    sel = MUL_ROLL;
      3'd2:    sel = MUL_YAW;
      3'd3:    sel = MUL_LIFT;
      default: sel = MUL_HOVER;
    endcase
    return sel;
  endfunction

  function automatic logic term_used(mix_mode_t mode, mul_sel_t sel);
    logic used;
    case (mode)
      MODE_FOUR_AXIS:  used = sel inside {MUL_PITCH, MUL_ROLL, MUL_YAW, MUL_LIFT};
      MODE_PITCH_ONLY: used = sel inside {MUL_PITCH, MUL_HOVER};
      MODE_ROLL_ONLY:  used = sel inside {MUL_ROLL, MUL_HOVER};
      default:         used = 1'b0;
    endcase
    return used;
  endfunction

  // X-frame sign pattern: true where the term is subtracted for that motor.
  function automatic logic term_negative(mul_sel_t sel, logic [MOTOR_W-1:0] motor);
    logic neg;
    case (sel)
      MUL_PITCH: neg = motor inside {2'd0, 2'd3};
      MUL_ROLL:  neg = motor inside {2'd0, 2'd1};
      MUL_YAW:   neg = motor inside {2'd0, 2'd2};
      default:   neg = 1'b0;
    endcase
    return neg;
  endfunction

endpackage

[sv/qmmt_ctrl.sv]
// Sequencing state machine of the motor mixer.
// Depends on qmmt_pkg and the assertion macro header.
`include "quad_motor_mixer_throttle_unit_assert.svh"

module qmmt_ctrl import qmmt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output ctl_cmd_t   cmd
);

  ctl_state_t              state_r, state_nxt;
  logic [TERM_CNT_W-1:0]   term_cnt_r, term_cnt_nxt;
  logic [MOTOR_W-1:0]      motor_r, motor_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    accept;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      term_cnt_r  <= '0;
      motor_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      term_cnt_r  <= term_cnt_nxt;
      motor_r     <= motor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    term_cnt_nxt = term_cnt_r;
    motor_nxt    = motor_r;
    cmd          = '0;
    cmd.mul_sel  = MUL_PITCH;
    cmd.motor    = motor_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in  = 1'b1;
          term_cnt_nxt = '0;
          state_nxt    = ST_MIX;
        end
      end
      ST_MIX: begin
        // Walk all five terms; the mode decides which ones reach the accumulators.
        cmd.mul_sel = term_of_index(term_cnt_r);
        cmd.mul_en  = term_used(status.mix_mode, cmd.mul_sel);
        if (term_cnt_r == LAST_TERM_INDEX) begin
          state_nxt = ST_MIX_DRAIN;
        end else begin
          term_cnt_nxt = term_cnt_r + 1'b1;
        end
      end
      ST_MIX_DRAIN: begin
        state_nxt = ST_FORCE;
      end
      ST_FORCE: begin
        cmd.force_load = (status.mix_mode != MODE_HOLD);
        motor_nxt      = '0;
        state_nxt      = ST_SQ;
      end
      ST_SQ: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_CURVE_SQ;
        state_nxt   = ST_UWAIT;
      end
      ST_UWAIT: begin
        state_nxt = ST_LO;
      end
      ST_LO: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_CURVE_LO;
        state_nxt   = ST_HI;
      end
      ST_HI: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_CURVE_HI;
        state_nxt   = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        cmd.cmp_write = 1'b1;
        if (motor_r == MOTOR_W'(MOTORS - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          motor_nxt = motor_r + 1'b1;
          state_nxt = ST_SQ;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  `QMMT_ASSERT_NEXT(a_accept_mix, clk, rst_n, accept, state_r == ST_MIX, "no mix after accept")
  `QMMT_ASSERT_NEXT(a_last_done, clk, rst_n, state_r == ST_CMP && motor_r == 2'd3, state_r == ST_DONE, "missed done")
  `QMMT_ASSERT_NEXT(a_hold_done, clk, rst_n, state_r == ST_DONE && out_valid_r && out_stall, state_r == ST_DONE, "result lost")

endmodule

[sv/qmmt_datapath.sv]
// Datapath of the motor mixer: registers, shared multiplier, accumulators, curve.
// Depends on qmmt_pkg and the assertion macro header.
`include "quad_motor_mixer_throttle_unit_assert.svh"

module qmmt_datapath import qmmt_pkg::*; #(
  parameter int FRAC_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ctl_cmd_t                      cmd,
  output dp_status_t                    status,
  input  logic                          cfg_we,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic signed [PITCH_W-1:0]     in_pitch_torque,
  input  logic signed [ROLL_W-1:0]      in_roll_torque,
  input  logic signed [YAW_W-1:0]       in_yaw_torque,
  input  logic [LIFT_W-1:0]             in_lift_accel,
  input  logic                          in_low_power,
  output logic [CMP_W-1:0]              out_motor1_compare,
  output logic [CMP_W-1:0]              out_motor2_compare,
  output logic [CMP_W-1:0]              out_motor3_compare,
  output logic [CMP_W-1:0]              out_motor4_compare
);

  // Force width, curve intermediate widths and multiplier operand widths.
  localparam int FW          = FRAC_BITS + FORCE_INT_BITS + 2;
  localparam int UW          = FRAC_BITS + 26;
  localparam int UL_W        = UW / 2;
  localparam int UH_W        = UW - UL_W;
  localparam int VW          = 2 * FRAC_BITS + 33;
  localparam int CURVE_SHIFT = 2 * FRAC_BITS + CURVE_BITS;
  localparam int TW          = VW - CURVE_SHIFT;
  localparam int GRAV_W      = FRAC_BITS + 4;
  localparam int GRAVITY_FX  = ((98 << FRAC_BITS) + 5) / 10;
  localparam int AW          = (FW > 19) ? FW : 19;
  localparam int BW0         = (FW > 15) ? FW : 15;
  localparam int BW1         = (BW0 > UL_W + 1) ? BW0 : UL_W + 1;
  localparam int BW          = (BW1 > UH_W) ? BW1 : UH_W;
  localparam int PW          = AW + BW;
  localparam int SW          = PW + 2;

  localparam logic signed [SW-1:0] FORCE_LIM   = SW'(1) <<< (FRAC_BITS + FORCE_INT_BITS);
  localparam logic signed [SW-1:0] FORCE_NEG   = -FORCE_LIM;
  localparam logic signed [FW-1:0] FORCE_MAX_F = FW'(FORCE_LIM);
  localparam logic signed [FW-1:0] FORCE_MIN_F = FW'(FORCE_NEG);
  localparam logic signed [UW-1:0] K1_SH       = UW'(CURVE_K1) <<< FRAC_BITS;
  localparam logic signed [VW-1:0] K0_SH       = VW'(CURVE_K0) <<< (2 * FRAC_BITS);
  localparam logic [CURVE_K2_W-1:0] K2_C       = CURVE_K2_W'(CURVE_K2);
  localparam logic [GRAV_W-1:0]    GRAV_C      = GRAV_W'(GRAVITY_FX);
  localparam logic signed [TW-1:0] T_MAX       = TW'(THR_MAX);
  localparam logic signed [TW-1:0] T_MIN       = TW'(THR_MIN);

  mix_mode_t                 mode_r;
  logic [ARM_GAIN_W-1:0]     arm_gain_r;
  logic [YAW_GAIN_W-1:0]     yaw_gain_r;
  logic [QMASS_W-1:0]        qmass_r;

  logic signed [PITCH_W-1:0] pitch_r;
  logic signed [ROLL_W-1:0]  roll_r;
  logic signed [YAW_W-1:0]   yaw_r;
  logic [LIFT_W-1:0]         lift_r;
  logic                      low_r;

  logic signed [AW-1:0]      mul_a;
  logic signed [BW-1:0]      mul_b;
  logic signed [FW-1:0]      f_sel;
  logic signed [PW-1:0]      prod_r;
  logic signed [SW-1:0]      prod_ext;
  logic                      prod_vld_r;
  mul_sel_t                  prod_tag_r;

  logic signed [SW-1:0]      acc_r     [MOTORS];
  logic signed [SW-1:0]      acc_shift [MOTORS];
  logic signed [FW-1:0]      force_sat [MOTORS];
  logic signed [FW-1:0]      force_r   [MOTORS];
  logic signed [UW-1:0]      u_r;
  logic signed [VW-1:0]      cacc_r;
  logic signed [TW-1:0]      t_val;
  logic signed [TW-1:0]      t_clamp;
  logic [CMP_W-1:0]          cmp_nxt;
  logic [CMP_W-1:0]          cmp_r     [MOTORS];
  logic [CMP_W-1:0]          out_cmp_r [MOTORS];
  logic                      forces_ok;

  assign status.mix_mode = mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_FOUR_AXIS;
      arm_gain_r <= '0;
      yaw_gain_r <= '0;
      qmass_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_MIX_MODE:     mode_r     <= mix_mode_t'(cfg_data[MODE_W-1:0]);
        CFG_ARM_GAIN:     arm_gain_r <= cfg_data[ARM_GAIN_W-1:0];
        CFG_YAW_GAIN:     yaw_gain_r <= cfg_data[YAW_GAIN_W-1:0];
        CFG_QUARTER_MASS: qmass_r    <= cfg_data[QMASS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      pitch_r <= in_pitch_torque;
      roll_r  <= in_roll_torque;
      yaw_r   <= in_yaw_torque;
      lift_r  <= in_lift_accel;
      low_r   <= in_low_power;
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    f_sel = force_r[cmd.motor];
    case (cmd.mul_sel)
      MUL_PITCH: begin
        mul_a = AW'(signed'({1'b0, arm_gain_r}));
        mul_b = BW'(pitch_r);
      end
      MUL_ROLL: begin
        mul_a = AW'(signed'({1'b0, arm_gain_r}));
        mul_b = BW'(roll_r);
      end
      MUL_YAW: begin
        mul_a = AW'(signed'({1'b0, yaw_gain_r}));
        mul_b = BW'(yaw_r);
      end
      MUL_LIFT: begin
        mul_a = AW'(signed'({1'b0, lift_r}));
        mul_b = BW'(signed'({1'b0, qmass_r}));
      end
      MUL_HOVER: begin
        mul_a = AW'(signed'({1'b0, GRAV_C}));
        mul_b = BW'(signed'({1'b0, qmass_r}));
      end
      MUL_CURVE_SQ: begin
        mul_a = AW'(signed'({1'b0, K2_C}));
        mul_b = BW'(f_sel);
      end
      MUL_CURVE_LO: begin
        mul_a = AW'(f_sel);
        mul_b = BW'(signed'({1'b0, u_r[UL_W-1:0]}));
      end
      MUL_CURVE_HI: begin
        mul_a = AW'(f_sel);
        mul_b = BW'(signed'(u_r[UW-1:UL_W]));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= PW'(mul_a) * PW'(mul_b);
    end
    prod_tag_r <= cmd.mul_sel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= cmd.mul_en;
    end
  end

  assign prod_ext = SW'(prod_r);

  // All four force sums build up in parallel as each mixing product arrives.
  always_ff @(posedge clk) begin
    for (int k = 0; k < MOTORS; k++) begin
      if (cmd.load_in) begin
        acc_r[k] <= '0;
      end else if (prod_vld_r &&
                   prod_tag_r inside {MUL_PITCH, MUL_ROLL, MUL_YAW, MUL_LIFT, MUL_HOVER}) begin
        acc_r[k] <= term_negative(prod_tag_r, MOTOR_W'(k)) ? acc_r[k] - prod_ext
                                                            : acc_r[k] + prod_ext;
      end
    end
  end

  // Arithmetic shift floors the exact sum, then saturate.
  always_comb begin
    for (int k = 0; k < MOTORS; k++) begin
      acc_shift[k] = acc_r[k] >>> FRAC_BITS;
      if (acc_shift[k] > FORCE_LIM) begin
        force_sat[k] = FORCE_MAX_F;
      end else if (acc_shift[k] < FORCE_NEG) begin
        force_sat[k] = FORCE_MIN_F;
      end else begin
        force_sat[k] = FW'(acc_shift[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MOTORS; k++) begin
        force_r[k] <= '0;
      end
    end else if (cmd.force_load) begin
      for (int k = 0; k < MOTORS; k++) begin
        force_r[k] <= force_sat[k];
      end
    end
  end

  // Curve by Horner's rule: v = f * (K2*f + K1*2^F) + K0*2^2F.
  // The second product is split into a low and a high partial product.
  always_ff @(posedge clk) begin
    if (prod_vld_r) begin
      case (prod_tag_r)
        MUL_CURVE_SQ: u_r    <= UW'(prod_r) + K1_SH;
        MUL_CURVE_LO: cacc_r <= VW'(prod_r) + K0_SH;
        MUL_CURVE_HI: cacc_r <= cacc_r + (VW'(prod_r) <<< UL_W);
        default: ;
      endcase
    end
  end

  always_comb begin
    t_val = signed'(cacc_r[VW-1:CURVE_SHIFT]);
    if (t_val > T_MAX) begin
      t_clamp = T_MAX;
    end else if (t_val < T_MIN) begin
      t_clamp = T_MIN;
    end else begin
      t_clamp = t_val;
    end
    cmp_nxt = CMP_W'(t_clamp) + CMP_W'(PWM_BASE);
  end

  always_ff @(posedge clk) begin
    if (cmd.cmp_write) begin
      cmp_r[cmd.motor] <= cmp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      for (int k = 0; k < MOTORS; k++) begin
        out_cmp_r[k] <= low_r ? CMP_W'(PWM_BASE) : cmp_r[k];
      end
    end
  end

  assign out_motor1_compare = out_cmp_r[0];
  assign out_motor2_compare = out_cmp_r[1];
  assign out_motor3_compare = out_cmp_r[2];
  assign out_motor4_compare = out_cmp_r[3];

  always_comb begin
    forces_ok = 1'b1;
    for (int k = 0; k < MOTORS; k++) begin
      if (force_r[k] > FORCE_MAX_F || force_r[k] < FORCE_MIN_F) begin
        forces_ok = 1'b0;
      end
    end
  end

  `QMMT_ASSERT_SAME(a_force_range, clk, rst_n, 1'b1, forces_ok, "stored force out of range")
  `QMMT_ASSERT_SAME(a_cmp_settled, clk, rst_n, cmd.cmp_write, !prod_vld_r, "curve not settled")
  `QMMT_ASSERT_SAME(a_mix_settled, clk, rst_n, cmd.force_load, !prod_vld_r, "mix not settled")

endmodule

[sv/quad_motor_mixer_throttle_unit.sv]
// Top level of the quadcopter X-frame motor mixer with throttle curve.
// Depends on qmmt_pkg, qmmt_ctrl and qmmt_datapath.
//
//   Channel   Handshake            Payload
//   --------  -------------------  ------------------------------------------------
//   input     in_valid / in_stall  pitch, roll, yaw torque, lift accel, low power
//   result    out_valid/out_stall  four motor compare values
//   config    cfg_we               cfg_index, cfg_data (no read-back)
//
// A transaction goes from acceptance to the output register through five mixing slots,
// a drain state, a force load, per motor the states SQ, UWAIT, LO, HI, DRAIN and CMP for
// three curve products on the shared multiplier and an output load, then accepts the next.
// Synchronous reset clears the configuration registers and the stored forces to zero.
// A stalled result holds in the output register while the next transaction is worked;
// that one then waits in its final step until the output register frees up.

module quad_motor_mixer_throttle_unit import qmmt_pkg::*; #(
  parameter int FRAC_BITS = 12
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [PITCH_W-1:0] in_pitch_torque,
  input  logic signed [ROLL_W-1:0]  in_roll_torque,
  input  logic signed [YAW_W-1:0]   in_yaw_torque,
  input  logic [LIFT_W-1:0]         in_lift_accel,
  input  logic                      in_low_power,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [CMP_W-1:0]          out_motor1_compare,
  output logic [CMP_W-1:0]          out_motor2_compare,
  output logic [CMP_W-1:0]          out_motor3_compare,
  output logic [CMP_W-1:0]          out_motor4_compare,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  qmmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  qmmt_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_pitch_torque    (in_pitch_torque),
    .in_roll_torque     (in_roll_torque),
    .in_yaw_torque      (in_yaw_torque),
    .in_lift_accel      (in_lift_accel),
    .in_low_power       (in_low_power),
    .out_motor1_compare (out_motor1_compare),
    .out_motor2_compare (out_motor2_compare),
    .out_motor3_compare (out_motor3_compare),
    .out_motor4_compare (out_motor4_compare)
  );

endmodule
